FILE: src/m2u_pkg.sv
// Shared types, codes and the word builder for the MIDI byte to UMP word converter.
package m2u_pkg;

   // UMP message types (top nibble of the first word)
   localparam logic [3:0] MT_SYSTEM  = 4'h1;
   localparam logic [3:0] MT_CHANNEL = 4'h2;
   localparam logic [3:0] MT_SYSEX7  = 4'h3;

   // SysEx7 packet kinds
   localparam logic [3:0] SX_COMPLETE = 4'h0;
   localparam logic [3:0] SX_START    = 4'h1;
   localparam logic [3:0] SX_CONTINUE = 4'h2;
   localparam logic [3:0] SX_END      = 4'h3;

   // SysEx payload bytes held per packet
   localparam int unsigned SX_MAX    = 6;
   localparam int unsigned SX_FILL_W = $clog2(SX_MAX + 1);
   localparam int unsigned SX_IDX_W  = $clog2(SX_MAX);

   // MIDI status codes
   localparam logic [7:0] ST_SYSEX_BEGIN = 8'hF0;
   localparam logic [7:0] ST_MTC_QFRAME  = 8'hF1;
   localparam logic [7:0] ST_SONG_POS    = 8'hF2;
   localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
   localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
   localparam logic [7:0] ST_SYSEX_EOX   = 8'hF7;
   localparam logic [7:0] ST_REALTIME    = 8'hF8;
   localparam logic [7:0] ST_SYSTEM      = 8'hF0;

   // Words one item may produce, and the queue between front and back
   localparam int unsigned MAX_WORDS = 3;
   localparam int unsigned NWORDS_W  = $clog2(MAX_WORDS + 1);
   localparam int unsigned Q_DEPTH   = 2;
   localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

   // Words produced by one item, first word in slot 0
   typedef struct packed {
      logic [NWORDS_W-1:0]           count;
      logic [MAX_WORDS-1:0][31:0]    word;
   } job_type;

   // System or channel voice word
   function automatic logic [31:0] make_word(logic [3:0] mt, logic [3:0] grp,
                                             logic [7:0] status, logic [6:0] d0,
                                             logic [6:0] d1);
      return {mt, grp, status, 1'b0, d0, 1'b0, d1};
   endfunction

endpackage

FILE: src/m2u_front.sv
// Front part: classifies each MIDI byte, keeps message state and builds its UMP words.
module m2u_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_midi_byte,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   input  logic              q_full,
   output logic              q_push,
   output m2u_pkg::job_type  q_job
);

   logic [3:0]                     group_ff;
   logic [7:0]                     pend_status_ff, pend_status_in;
   logic [1:0]                     pend_rem_ff, pend_rem_in;
   logic [1:0]                     pend_cnt_ff, pend_cnt_in;
   logic [6:0]                     pend_data_ff [2];
   logic [7:0]                     run_status_ff, run_status_in;
   logic                           sx_open_ff, sx_open_in;
   logic                           sx_sent_ff, sx_sent_in;
   logic [m2u_pkg::SX_FILL_W-1:0]  sx_fill_ff, sx_fill_in;
   logic [6:0]                     sx_bytes_ff [m2u_pkg::SX_MAX];

   logic                           accept;
   logic [7:0]                     b;
   logic [6:0]                     sxb [m2u_pkg::SX_MAX];
   logic [3:0]                     fl_kind;
   logic [31:0]                    fl_w0, fl_w1;
   logic                           sx_we;
   logic [m2u_pkg::SX_IDX_W-1:0]   sx_widx;
   logic                           pd_we;
   logic                           pd_idx;
   logic [6:0]                     data0, data1;
   logic [7:0]                     st;
   logic [1:0]                     rem, cnt;
   logic [m2u_pkg::NWORDS_W-1:0]   nw;
   m2u_pkg::job_type               job;

   function automatic logic [1:0] chan_len(logic [7:0] s);
      return (s[7:4] == 4'hC || s[7:4] == 4'hD) ? 2'd1 : 2'd2;
   endfunction

   assign b         = req_midi_byte;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   // Mask buffered SysEx bytes at or beyond the fill level
   always_comb begin
      for (int i = 0; i < m2u_pkg::SX_MAX; i++) begin
         sxb[i] = (m2u_pkg::SX_FILL_W'(i) < sx_fill_ff) ? sx_bytes_ff[i] : 7'd0;
      end
   end

   // Build the two words of a SysEx flush; kind depends on what triggered it
   always_comb begin
      if (b[7]) begin
         fl_kind = sx_sent_ff ? m2u_pkg::SX_END : m2u_pkg::SX_COMPLETE;
      end else begin
         fl_kind = sx_sent_ff ? m2u_pkg::SX_CONTINUE : m2u_pkg::SX_START;
      end
      fl_w0 = {m2u_pkg::MT_SYSEX7, group_ff, fl_kind, 1'b0, sx_fill_ff,
               1'b0, sxb[0], 1'b0, sxb[1]};
      fl_w1 = {1'b0, sxb[2], 1'b0, sxb[3], 1'b0, sxb[4], 1'b0, sxb[5]};
   end

   // Classify the byte, update state and collect its words
   always_comb begin
      pend_status_in = pend_status_ff;
      pend_rem_in    = pend_rem_ff;
      pend_cnt_in    = pend_cnt_ff;
      run_status_in  = run_status_ff;
      sx_open_in     = sx_open_ff;
      sx_sent_in     = sx_sent_ff;
      sx_fill_in     = sx_fill_ff;
      sx_we          = 1'b0;
      sx_widx        = sx_fill_ff[m2u_pkg::SX_IDX_W-1:0];
      pd_we          = 1'b0;
      pd_idx         = pend_cnt_ff[0];
      data0          = pend_data_ff[0];
      data1          = pend_data_ff[1];
      st             = pend_status_ff;
      rem            = pend_rem_ff;
      cnt            = pend_cnt_ff;
      nw             = '0;
      job            = '0;

      if (b[7]) begin
         if (b >= m2u_pkg::ST_REALTIME) begin
            // real-time: one system word, nothing else moves
            job.word[0] = m2u_pkg::make_word(m2u_pkg::MT_SYSTEM, group_ff, b, 7'd0, 7'd0);
            nw          = m2u_pkg::NWORDS_W'(1);
         end else begin
            // any other status closes an open SysEx first
            if (sx_open_ff) begin
               job.word[0] = fl_w0;
               job.word[1] = fl_w1;
               nw          = m2u_pkg::NWORDS_W'(2);
               sx_open_in  = 1'b0;
               sx_sent_in  = 1'b0;
               sx_fill_in  = '0;
            end
            if (b < m2u_pkg::ST_SYSTEM) begin
               // channel status: start a message and set running status
               pend_status_in = b;
               pend_rem_in    = chan_len(b);
               pend_cnt_in    = 2'd0;
               run_status_in  = b;
            end else begin
               run_status_in  = 8'd0;
               pend_status_in = 8'd0;
               pend_rem_in    = 2'd0;
               pend_cnt_in    = 2'd0;
               if (b == m2u_pkg::ST_SYSEX_BEGIN) begin
                  sx_open_in = 1'b1;
                  sx_sent_in = 1'b0;
                  sx_fill_in = '0;
               end else if (b == m2u_pkg::ST_TUNE_REQ) begin
                  if (sx_open_ff) begin
                     job.word[2] = m2u_pkg::make_word(m2u_pkg::MT_SYSTEM, group_ff, b,
                                                      7'd0, 7'd0);
                  end else begin
                     job.word[0] = m2u_pkg::make_word(m2u_pkg::MT_SYSTEM, group_ff, b,
                                                      7'd0, 7'd0);
                  end
                  nw = nw + m2u_pkg::NWORDS_W'(1);
               end else if (b inside {m2u_pkg::ST_MTC_QFRAME, m2u_pkg::ST_SONG_SEL}) begin
                  pend_status_in = b;
                  pend_rem_in    = 2'd1;
               end else if (b == m2u_pkg::ST_SONG_POS) begin
                  pend_status_in = b;
                  pend_rem_in    = 2'd2;
               end
            end
         end
      end else if (sx_open_ff) begin
         // SysEx payload: flush a full buffer, then store the byte
         sx_we = 1'b1;
         if (sx_fill_ff == m2u_pkg::SX_FILL_W'(m2u_pkg::SX_MAX)) begin
            job.word[0] = fl_w0;
            job.word[1] = fl_w1;
            nw          = m2u_pkg::NWORDS_W'(2);
            sx_sent_in  = 1'b1;
            sx_widx     = '0;
            sx_fill_in  = m2u_pkg::SX_FILL_W'(1);
         end else begin
            sx_fill_in  = sx_fill_ff + m2u_pkg::SX_FILL_W'(1);
         end
      end else if (pend_rem_ff != 2'd0 || run_status_ff != 8'd0) begin
         // data byte of a message; reopen from running status if idle
         if (pend_rem_ff == 2'd0) begin
            st  = run_status_ff;
            rem = chan_len(run_status_ff);
            cnt = 2'd0;
         end
         pd_we  = 1'b1;
         pd_idx = cnt[0];
         if (cnt[0]) begin
            data1 = b[6:0];
         end else begin
            data0 = b[6:0];
         end
         if (cnt != 2'd2) begin
            cnt = cnt + 2'd1;
         end
         rem = rem - 2'd1;
         if (rem == 2'd0) begin
            job.word[0] = m2u_pkg::make_word(
               (st < m2u_pkg::ST_SYSTEM) ? m2u_pkg::MT_CHANNEL : m2u_pkg::MT_SYSTEM,
               group_ff, st,
               (cnt != 2'd0) ? data0 : 7'd0,
               (cnt == 2'd2) ? data1 : 7'd0);
            nw  = m2u_pkg::NWORDS_W'(1);
            cnt = 2'd0;
            st  = 8'd0;
         end
         pend_status_in = st;
         pend_rem_in    = rem;
         pend_cnt_in    = cnt;
      end

      job.count = nw;
   end

   assign q_push = accept && (nw != '0);
   assign q_job  = job;

   // Hold control state; the group follows CSR writes, the rest advances only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff       <= 4'd0;
         pend_status_ff <= 8'd0;
         pend_rem_ff    <= 2'd0;
         pend_cnt_ff    <= 2'd0;
         run_status_ff  <= 8'd0;
         sx_open_ff     <= 1'b0;
         sx_sent_ff     <= 1'b0;
         sx_fill_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            group_ff <= csr_wr_data;
         end
         if (accept) begin
            pend_status_ff <= pend_status_in;
            pend_rem_ff    <= pend_rem_in;
            pend_cnt_ff    <= pend_cnt_in;
            run_status_ff  <= run_status_in;
            sx_open_ff     <= sx_open_in;
            sx_sent_ff     <= sx_sent_in;
            sx_fill_ff     <= sx_fill_in;
         end
      end
   end

   // Payload stores: message data bytes and the SysEx buffer
   always_ff @(posedge clock) begin
      if (accept && pd_we) begin
         pend_data_ff[pd_idx] <= b[6:0];
      end
      if (accept && sx_we) begin
         sx_bytes_ff[sx_widx] <= b[6:0];
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      sx_fill_ff <= m2u_pkg::SX_FILL_W'(m2u_pkg::SX_MAX))
      else $error("SysEx fill beyond buffer size");

   a_fill_closed: assert property (@(posedge clock) disable iff (reset)
      !sx_open_ff |-> sx_fill_ff == '0)
      else $error("SysEx bytes buffered with no SysEx open");

   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      pend_rem_ff == 2'd0 |-> pend_cnt_ff == 2'd0)
      else $error("data count left over with no message pending");

endmodule

FILE: src/m2u_queue.sv
// Short queue of built word groups between front and back parts.
module m2u_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  m2u_pkg::job_type  push_job,
   output logic              full,
   input  logic              pop,
   output m2u_pkg::job_type  head_job,
   output logic              empty
);

   m2u_pkg::job_type                slot_ff [m2u_pkg::Q_DEPTH];
   logic [m2u_pkg::Q_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [m2u_pkg::Q_CNT_W-1:0]     cnt_ff;
   logic                            do_push, do_pop;

   assign full     = cnt_ff == m2u_pkg::Q_CNT_W'(m2u_pkg::Q_DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == m2u_pkg::Q_PTR_W'(m2u_pkg::Q_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + m2u_pkg::Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == m2u_pkg::Q_PTR_W'(m2u_pkg::Q_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + m2u_pkg::Q_PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + m2u_pkg::Q_CNT_W'(1);
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - m2u_pkg::Q_CNT_W'(1);
         end
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into a full queue");

endmodule

FILE: src/m2u_back.sv
// Back part: holds one word group and hands its words out one per handshake.
module m2u_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  m2u_pkg::job_type  q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_ump_word,
   output logic              rsp_last_word
);

   m2u_pkg::job_type                cur_ff;
   logic [m2u_pkg::NWORDS_W-1:0]    idx_ff;
   logic                            busy_ff;
   logic                            last;
   logic                            load;

   assign last      = idx_ff == cur_ff.count - m2u_pkg::NWORDS_W'(1);
   assign load      = !q_empty && (!busy_ff || (rsp_ready && last));
   assign q_pop     = load;
   assign rsp_valid = busy_ff;
   assign rsp_last_word = last;

   // Select the current word
   always_comb begin
      case (idx_ff)
         m2u_pkg::NWORDS_W'(0): rsp_ump_word = cur_ff.word[0];
         m2u_pkg::NWORDS_W'(1): rsp_ump_word = cur_ff.word[1];
         m2u_pkg::NWORDS_W'(2): rsp_ump_word = cur_ff.word[2];
         default:               rsp_ump_word = cur_ff.word[0];
      endcase
   end

   // Advance through the group; load the next one when idle or as the last word leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_ready) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + m2u_pkg::NWORDS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_job;
      end
   end

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff < cur_ff.count && cur_ff.count != '0))
      else $error("word index outside the held group");

endmodule

FILE: src/midi_bytes_to_ump_words.sv
// Top level: MIDI 1.0 byte stream to Universal MIDI Packet word converter.
//
//   channel   ports                          direction   moves
//   req       req_valid/ready, req_midi_byte in          one MIDI byte per item
//   rsp       rsp_valid/ready, rsp_ump_word, out         one UMP word per item
//             rsp_last_word
//   csr       csr_wr_en, csr_wr_data         in          UMP group, no wait
//
// A byte is taken when req_valid and req_ready are both high; classification, state
// update and word building are done in that cycle and queued. Words leave at one per
// cycle while rsp_ready is high; the two-entry queue plus the output register decide
// how far the input runs ahead of a stalled output.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// The input stalls only when the queue is full.
module midi_bytes_to_ump_words (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_midi_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_ump_word,
   output logic        rsp_last_word,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   logic              q_push, q_full, q_pop, q_empty;
   m2u_pkg::job_type  push_job, head_job;

   m2u_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_midi_byte (req_midi_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_job         (push_job)
   );

   m2u_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   m2u_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_job         (head_job),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ump_word  (rsp_ump_word),
      .rsp_last_word (rsp_last_word)
   );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the MIDI 1.0 byte to UMP word converter.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   // Status codes that the package does not name
   localparam logic [7:0] ST_NOTE_OFF   = 8'h80;
   localparam logic [7:0] ST_NOTE_ON    = 8'h90;
   localparam logic [7:0] ST_PROG_CHG   = 8'hC0;
   localparam logic [7:0] ST_UNDEF_F4   = 8'hF4;
   localparam logic [7:0] ST_UNDEF_F5   = 8'hF5;
   localparam logic [7:0] ST_SYS_RESET  = 8'hFF;
   localparam logic [3:0] HI_PROG_CHG   = 4'hC;
   localparam logic [3:0] HI_CH_PRESS   = 4'hD;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } ump_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_midi_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_ump_word;
   logic        rsp_last_word;
   logic        csr_wr_en = 1'b0;
   logic [3:0]  csr_wr_data = 4'h0;

   // Bytes waiting to be sent, and words the converter still owes
   logic [7:0]    midi_in_q[$];
   ump_beat_type  ump_expect_q[$];
   ump_beat_type  due;

   // Converter state as seen by the predictor
   logic [3:0]  grp_model = 4'h0;
   logic [7:0]  pend_st = 8'h00;
   logic [1:0]  pend_left = 2'd0;
   logic [1:0]  pend_n = 2'd0;
   logic [6:0]  pend_d [2] = '{7'h00, 7'h00};
   logic [7:0]  run_st = 8'h00;
   bit          sx_open = 1'b0;
   bit          sx_sent = 1'b0;
   logic [3:0]  sx_fill = 4'd0;
   logic [6:0]  sx_buf [6];

   // Words produced by the byte under prediction
   logic [31:0] step_words [3];
   int          step_n;

   bit          snd_idle = 1'b0;
   bit          rcv_idle = 1'b0;
   int          snd_wait;
   int          rcv_wait;
   int          errors = 0;
   int          bytes_sent = 0;
   int          words_checked = 0;
   int          sx_packets = 0;
   int          group_writes = 0;

   // Opening sequence: note on, running status, program change, song position,
   // tune request, undefined F4/F5 around an orphan data byte, stray EOX, a SysEx
   // that overflows its buffer with real-time inside, a restart that closes it
   // as End, and a channel status that closes the new one as Complete.
   logic [7:0]  opening_bytes [27] = '{
      ST_NOTE_ON, 8'h00, 8'h7F,
      8'h7F, 8'h00,
      ST_PROG_CHG | 8'h05, 8'h7F,
      m2u_pkg::ST_SONG_POS, 8'h01, 8'h7F,
      m2u_pkg::ST_TUNE_REQ,
      ST_UNDEF_F4, 8'h12, ST_UNDEF_F5,
      m2u_pkg::ST_SYSEX_EOX,
      m2u_pkg::ST_SYSEX_BEGIN, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
      ST_SYS_RESET,
      m2u_pkg::ST_SYSEX_BEGIN, 8'h7E,
      ST_NOTE_OFF
   };

   midi_bytes_to_ump_words u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_midi_byte (req_midi_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ump_word  (rsp_ump_word),
      .rsp_last_word (rsp_last_word),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   task automatic flag_error(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      errors++;
   endtask

   function automatic int pick_gap(input bit enabled);
      if (!enabled || $urandom_range(0, 2) == 0) return 0;
      return int'($urandom_range(0, 18));
   endfunction

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic void put_word(input logic [31:0] w);
      if (step_n < m2u_pkg::MAX_WORDS) begin
         step_words[step_n] = w;
         step_n++;
      end
   endfunction

   function automatic logic [31:0] short_word(input logic [3:0] mt, input logic [7:0] st,
                                              input logic [6:0] d0, input logic [6:0] d1);
      return {mt, grp_model, st, 1'b0, d0, 1'b0, d1};
   endfunction

   function automatic logic [1:0] data_len(input logic [7:0] st);
      return (st[7:4] == HI_PROG_CHG || st[7:4] == HI_CH_PRESS) ? 2'd1 : 2'd2;
   endfunction

   function automatic logic [6:0] sx_at(input int i);
      return (i < sx_fill) ? sx_buf[i] : 7'h00;
   endfunction

   // Pack the buffered SysEx payload into one two-word packet
   function automatic void sx_send(input logic [3:0] kind);
      put_word({m2u_pkg::MT_SYSEX7, grp_model, kind, sx_fill, 1'b0, sx_at(0), 1'b0,
                sx_at(1)});
      put_word({1'b0, sx_at(2), 1'b0, sx_at(3), 1'b0, sx_at(4), 1'b0, sx_at(5)});
      sx_fill = 4'd0;
      sx_sent = 1'b1;
      sx_packets++;
   endfunction

   function automatic void sx_close();
      if (!sx_open) return;
      sx_send(sx_sent ? m2u_pkg::SX_END : m2u_pkg::SX_COMPLETE);
      sx_open = 1'b0;
      sx_sent = 1'b0;
   endfunction

   function automatic void drop_partial();
      pend_st = 8'h00;
      pend_left = 2'd0;
      pend_n = 2'd0;
   endfunction

   function automatic void take_status(input logic [7:0] b);
      if (b >= m2u_pkg::ST_REALTIME) begin
         put_word(short_word(m2u_pkg::MT_SYSTEM, b, 7'h00, 7'h00));
         return;
      end
      if (b == m2u_pkg::ST_SYSEX_BEGIN) begin
         sx_close();
         sx_open = 1'b1;
         sx_sent = 1'b0;
         sx_fill = 4'd0;
         run_st = 8'h00;
         drop_partial();
         return;
      end
      if (b == m2u_pkg::ST_SYSEX_EOX) begin
         sx_close();
         run_st = 8'h00;
         drop_partial();
         return;
      end
      sx_close();
      // Channel status starts a message and becomes the running status
      if (b < m2u_pkg::ST_SYSTEM) begin
         pend_st = b;
         pend_left = data_len(b);
         pend_n = 2'd0;
         run_st = b;
         return;
      end
      run_st = 8'h00;
      drop_partial();
      case (b)
         m2u_pkg::ST_TUNE_REQ: begin
            put_word(short_word(m2u_pkg::MT_SYSTEM, b, 7'h00, 7'h00));
         end
         m2u_pkg::ST_MTC_QFRAME, m2u_pkg::ST_SONG_SEL: begin
            pend_st = b;
            pend_left = 2'd1;
         end
         m2u_pkg::ST_SONG_POS: begin
            pend_st = b;
            pend_left = 2'd2;
         end
         default: ;
      endcase
   endfunction

   function automatic void take_data(input logic [6:0] d);
      logic [6:0] d0;
      logic [6:0] d1;
      logic [7:0] st;
      // Inside SysEx: flush a full buffer, then store
      if (sx_open) begin
         if (sx_fill >= m2u_pkg::SX_MAX)
            sx_send(sx_sent ? m2u_pkg::SX_CONTINUE : m2u_pkg::SX_START);
         sx_buf[sx_fill] = d;
         sx_fill++;
         return;
      end
      if (pend_left == 2'd0) begin
         if (run_st == 8'h00) return;
         pend_st = run_st;
         pend_left = data_len(run_st);
         pend_n = 2'd0;
      end
      pend_d[pend_n[0]] = d;
      if (pend_n < 2'd2) pend_n++;
      pend_left--;
      if (pend_left != 2'd0) return;
      d0 = (pend_n > 2'd0) ? pend_d[0] : 7'h00;
      d1 = (pend_n > 2'd1) ? pend_d[1] : 7'h00;
      st = pend_st;
      pend_n = 2'd0;
      pend_st = 8'h00;
      put_word(short_word((st < m2u_pkg::ST_SYSTEM) ? m2u_pkg::MT_CHANNEL :
                          m2u_pkg::MT_SYSTEM, st, d0, d1));
   endfunction

   // Work out the words one accepted byte produces and queue them
   function automatic void convert_byte(input logic [7:0] b);
      ump_beat_type beat;
      step_n = 0;
      if (b[7]) take_status(b);
      else take_data(b[6:0]);
      for (int i = 0; i < step_n; i++) begin
         beat.word = step_words[i];
         beat.last = (i == step_n - 1);
         ump_expect_q.push_back(beat);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Driver: present one byte at a time, with a random gap after each item
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         snd_wait = 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            convert_byte(req_midi_byte);
            bytes_sent++;
            snd_wait = pick_gap(snd_idle);
         end
         if (snd_wait == 0 && midi_in_q.size() != 0) begin
            req_valid <= 1'b1;
            req_midi_byte <= midi_in_q.pop_front();
         end else begin
            req_valid <= 1'b0;
            if (snd_wait != 0) snd_wait--;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: check each accepted word, then stall ready at random
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rcv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (ump_expect_q.size() == 0) begin
               flag_error($sformatf("unexpected word %08h", rsp_ump_word));
            end else begin
               due = ump_expect_q.pop_front();
               words_checked++;
               if (rsp_ump_word !== due.word)
                  flag_error($sformatf("ump_word %08h, expected %08h",
                                       rsp_ump_word, due.word));
               if (rsp_last_word !== due.last)
                  flag_error($sformatf("last_word %0b, expected %0b on word %08h",
                                       rsp_last_word, due.last, due.word));
            end
            rcv_wait = pick_gap(rcv_idle);
         end
         if (rcv_wait == 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            rcv_wait--;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   // Write the group register; only called with the converter idle
   task automatic set_group(input logic [3:0] g);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      grp_model = g;
      group_writes++;
      @(negedge clock);
   endtask

   // Hold until every byte is taken and every word has come, then let the pipe drain
   task automatic wait_idle();
      do @(negedge clock);
      while (midi_in_q.size() != 0 || req_valid || ump_expect_q.size() != 0);
      repeat (12) @(negedge clock);
   endtask

   function automatic logic [7:0] rand_data();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'h7F;
         default: return 8'($urandom_range(0, 127));
      endcase
   endfunction

   // Mostly well-formed messages with random content, some broken ones and noise
   task automatic queue_messages(input int target);
      int pushed;
      int kind;
      int n;
      int len;
      logic [7:0] st;
      pushed = 0;
      while (pushed < target) begin
         kind = int'($urandom_range(0, 99));
         if (kind < 35) begin
            // channel message, maybe followed by running-status repeats
            st = 8'($urandom_range(ST_NOTE_OFF, m2u_pkg::ST_SYSTEM - 1));
            midi_in_q.push_back(st);
            pushed++;
            len = int'(data_len(st));
            if ($urandom_range(0, 7) == 0) len--;
            n = int'($urandom_range(0, 2)) * int'(data_len(st));
            for (int i = 0; i < len + n; i++) begin
               midi_in_q.push_back(rand_data());
               pushed++;
            end
         end else if (kind < 45) begin
            // system common with its data bytes
            case ($urandom_range(0, 2))
               0: begin st = m2u_pkg::ST_MTC_QFRAME; len = 1; end
               1: begin st = m2u_pkg::ST_SONG_SEL;   len = 1; end
               default: begin st = m2u_pkg::ST_SONG_POS; len = 2; end
            endcase
            midi_in_q.push_back(st);
            pushed++;
            for (int i = 0; i < len; i++) begin
               midi_in_q.push_back(rand_data());
               pushed++;
            end
         end else if (kind < 55) begin
            midi_in_q.push_back(8'($urandom_range(m2u_pkg::ST_REALTIME, ST_SYS_RESET)));
            pushed++;
         end else if (kind < 80) begin
            // SysEx with real-time sprinkled in, mostly closed by EOX
            n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 20)) :
                                              int'($urandom_range(0, 8));
            midi_in_q.push_back(m2u_pkg::ST_SYSEX_BEGIN);
            pushed++;
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  midi_in_q.push_back(8'($urandom_range(m2u_pkg::ST_REALTIME,
                                                        ST_SYS_RESET)));
                  pushed++;
               end
               midi_in_q.push_back(rand_data());
               pushed++;
            end
            case ($urandom_range(0, 9))
               7: midi_in_q.push_back(m2u_pkg::ST_SYSEX_BEGIN);
               8, 9: midi_in_q.push_back(8'($urandom_range(ST_NOTE_OFF,
                                                           m2u_pkg::ST_TUNE_REQ)));
               default: midi_in_q.push_back(m2u_pkg::ST_SYSEX_EOX);
            endcase
            pushed++;
         end else if (kind < 90) begin
            case ($urandom_range(0, 3))
               0: midi_in_q.push_back(ST_UNDEF_F4);
               1: midi_in_q.push_back(ST_UNDEF_F5);
               2: midi_in_q.push_back(m2u_pkg::ST_TUNE_REQ);
               default: midi_in_q.push_back(m2u_pkg::ST_SYSEX_EOX);
            endcase
            pushed++;
         end else begin
            midi_in_q.push_back(8'($urandom_range(0, 255)));
            pushed++;
         end
      end
   endtask

   // Main sequence: directed opening, then random phases at several group settings
   initial begin
      logic [3:0] groups [4];
      bit         snd_mode [4];
      bit         rcv_mode [4];
      groups = '{4'hF, 4'h5, 4'hA, 4'($urandom_range(0, 15))};
      snd_mode = '{1'b1, 1'b0, 1'b1, 1'b1};
      rcv_mode = '{1'b1, 1'b0, 1'b0, 1'b1};

      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_group(4'h0);
      snd_idle = 1'b0;
      rcv_idle = 1'b1;
      foreach (opening_bytes[i]) midi_in_q.push_back(opening_bytes[i]);
      wait_idle();

      for (int ph = 0; ph < 4; ph++) begin
         set_group(groups[ph]);
         snd_idle = snd_mode[ph];
         rcv_idle = rcv_mode[ph];
         queue_messages(18);
         wait_idle();
      end

      $display("Sent %0d MIDI bytes under %0d group settings, including 0 and 15.",
               bytes_sent, group_writes);
      $display("Checked %0d UMP words, %0d of them in %0d SysEx7 packets.",
               words_checked, 2 * sx_packets, sx_packets);
      if (errors == 0) begin
         $display("midi_bytes_to_ump_words test passed");
      end else begin
         $display("midi_bytes_to_ump_words test failed");
      end
      $finish;
   end

   // Guard against a hang
   initial begin
      #5_000_000;
      $display("Timed out with %0d words still expected.", ump_expect_q.size());
      $display("midi_bytes_to_ump_words test failed");
      $finish;
   end

endmodule
